// File: rtl/smrd_pkg.sv
// ----------------------------------------------------------------------------
// smrd_pkg: shared types for the sign-magnitude restoring divider
// Holds the per-transaction flags that travel down the division pipeline.
// ----------------------------------------------------------------------------
package smrd_pkg;

  // Flags that ride alongside the datapath of each transaction.
  typedef struct packed {
    logic remainder_neg;  // dividend was negative
    logic quotient_neg;   // operand signs differ
    logic overflow;       // high dividend half >= divisor, results forced to zero
  } smrd_flags_t;

endpackage

// File: rtl/smrd_ifs.sv
// ----------------------------------------------------------------------------
// smrd_ifs: operand and result channels of the divider
// Valid/ready channels; a transaction moves when valid and ready are high.
// ----------------------------------------------------------------------------
interface smrd_in_if #(
  parameter int WIDTH = 16
);
  logic                   valid;
  logic                   ready;
  logic                   dividend_sign;
  logic [2*WIDTH-1:0]     dividend_magnitude;
  logic                   divisor_sign;
  logic [WIDTH-1:0]       divisor_magnitude;

  modport source (
    output valid, dividend_sign, dividend_magnitude, divisor_sign, divisor_magnitude,
    input  ready
  );
  modport sink (
    input  valid, dividend_sign, dividend_magnitude, divisor_sign, divisor_magnitude,
    output ready
  );
endinterface

interface smrd_out_if #(
  parameter int WIDTH = 16
);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] quotient_bits;
  logic [WIDTH-1:0] remainder_bits;
  logic             overflow;

  modport source (
    output valid, quotient_bits, remainder_bits, overflow,
    input  ready
  );
  modport sink (
    input  valid, quotient_bits, remainder_bits, overflow,
    output ready
  );
endinterface

// File: rtl/smrd_entry.sv
// ----------------------------------------------------------------------------
// smrd_entry: first pipeline stage of the divider
// Checks for overflow and loads the partial remainder, low word and divisor.
// ----------------------------------------------------------------------------
module smrd_entry #(
  parameter int WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  dividend_sign,
  input  logic [2*WIDTH-1:0]    dividend_magnitude,
  input  logic                  divisor_sign,
  input  logic [WIDTH-1:0]      divisor_magnitude,
  output logic                  valid,
  input  logic                  out_ready,
  output smrd_pkg::smrd_flags_t flags,
  output logic [WIDTH-1:0]      acc,
  output logic [WIDTH-1:0]      low,
  output logic [WIDTH-1:0]      divisor
);
  import smrd_pkg::*;

  logic [WIDTH-1:0] high_half;
  smrd_flags_t      flags_next;

  // The stage takes a new transaction when it is empty or its contents move on.
  assign in_ready = !valid || out_ready;

  // A zero divisor always lands here, since the high half is never below zero.
  assign high_half = dividend_magnitude[2*WIDTH-1:WIDTH];

  always_comb begin
    flags_next.remainder_neg = dividend_sign;
    flags_next.quotient_neg  = dividend_sign ^ divisor_sign;
    flags_next.overflow      = (high_half >= divisor_magnitude);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      flags   <= flags_next;
      acc     <= high_half;
      low     <= dividend_magnitude[WIDTH-1:0];
      divisor <= divisor_magnitude;
    end
  end

endmodule

// File: rtl/smrd_step.sv
// ----------------------------------------------------------------------------
// smrd_step: one restoring shift-subtract step
// Shifts one dividend bit into the partial remainder, subtracts the divisor
// when it fits and records the quotient bit, then registers the result.
// ----------------------------------------------------------------------------
module smrd_step #(
  parameter int WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  smrd_pkg::smrd_flags_t in_flags,
  input  logic [WIDTH-1:0]      in_acc,
  input  logic [WIDTH-1:0]      in_low,
  input  logic [WIDTH-1:0]      in_divisor,
  output logic                  valid,
  input  logic                  out_ready,
  output smrd_pkg::smrd_flags_t flags,
  output logic [WIDTH-1:0]      acc,
  output logic [WIDTH-1:0]      low,
  output logic [WIDTH-1:0]      divisor
);
  import smrd_pkg::*;

  logic [WIDTH:0]   shifted;
  logic [WIDTH+1:0] diff;
  logic             fits;
  logic [WIDTH-1:0] acc_next;
  logic [WIDTH-1:0] low_next;

  assign in_ready = !valid || out_ready;

  // Trial subtraction; a clear top bit means the divisor fits.
  assign shifted = {in_acc, in_low[WIDTH-1]};
  assign diff    = {1'b0, shifted} - {2'b00, in_divisor};
  assign fits    = !diff[WIDTH+1];

  // Either result stays below the divisor, so WIDTH bits hold it.
  assign acc_next = fits ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
  assign low_next = {in_low[WIDTH-2:0], fits};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      flags   <= in_flags;
      acc     <= acc_next;
      low     <= low_next;
      divisor <= in_divisor;
    end
  end

endmodule

// File: rtl/smrd_fixup.sv
// ----------------------------------------------------------------------------
// smrd_fixup: sign correction and output register
// Applies the result signs, forces zero results on overflow and holds the
// finished transaction until the result channel takes it.
// ----------------------------------------------------------------------------
module smrd_fixup #(
  parameter int WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  smrd_pkg::smrd_flags_t in_flags,
  input  logic [WIDTH-1:0]      in_acc,
  input  logic [WIDTH-1:0]      in_low,
  output logic                  valid,
  input  logic                  out_ready,
  output logic [WIDTH-1:0]      quotient_bits,
  output logic [WIDTH-1:0]      remainder_bits,
  output logic                  overflow
);
  import smrd_pkg::*;

  logic [WIDTH-1:0] quotient_next;
  logic [WIDTH-1:0] remainder_next;

  assign in_ready = !valid || out_ready;

  // Two's-complement negation; zero negates to zero on its own.
  always_comb begin
    if (in_flags.overflow) begin
      quotient_next  = '0;
      remainder_next = '0;
    end else begin
      quotient_next  = in_flags.quotient_neg  ? ('0 - in_low) : in_low;
      remainder_next = in_flags.remainder_neg ? ('0 - in_acc) : in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      quotient_bits  <= quotient_next;
      remainder_bits <= remainder_next;
      overflow       <= in_flags.overflow;
    end
  end

endmodule

// File: rtl/sign_magnitude_restoring_divider_unit.sv
// ----------------------------------------------------------------------------
// sign_magnitude_restoring_divider_unit: pipelined sign-magnitude divider
// Divides a sign and 2*WIDTH-bit magnitude by a sign and WIDTH-bit magnitude
// with one restoring step per pipeline stage.
//
//   Channel   Direction  Contents
//   operand   in         dividend_sign, dividend_magnitude, divisor_sign,
//                        divisor_magnitude
//   result    out        quotient_bits, remainder_bits, overflow
//
// A new transaction can enter every cycle unless the result channel stalls; the
// stages are the entry check, WIDTH subtract stages and sign fix-up with output register.
// Every stage carries its own valid bit and moves on when empty or when the
// stage after it moves, so bubbles close up and a stall loses nothing.
// Synchronous reset clears only the valid bits.
// ----------------------------------------------------------------------------
module sign_magnitude_restoring_divider_unit #(
  parameter int WIDTH = 16
) (
  input  logic            clk,
  input  logic            rst,
  smrd_in_if.sink         operand,
  smrd_out_if.source      result
);
  import smrd_pkg::*;

  // Stage k holds the state after k restoring steps.
  logic             stage_valid   [0:WIDTH];
  logic             stage_ready   [0:WIDTH];
  smrd_flags_t      stage_flags   [0:WIDTH];
  logic [WIDTH-1:0] stage_acc     [0:WIDTH];
  logic [WIDTH-1:0] stage_low     [0:WIDTH];
  logic [WIDTH-1:0] stage_divisor [0:WIDTH];
  logic             fixup_ready;

  // Overflow check and operand load.
  smrd_entry #(.WIDTH(WIDTH)) u_entry (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (operand.valid),
    .in_ready           (operand.ready),
    .dividend_sign      (operand.dividend_sign),
    .dividend_magnitude (operand.dividend_magnitude),
    .divisor_sign       (operand.divisor_sign),
    .divisor_magnitude  (operand.divisor_magnitude),
    .valid              (stage_valid[0]),
    .out_ready          (stage_ready[0]),
    .flags              (stage_flags[0]),
    .acc                (stage_acc[0]),
    .low                (stage_low[0]),
    .divisor            (stage_divisor[0])
  );

  // One shift-subtract step per stage.
  for (genvar k = 0; k < WIDTH; k++) begin : g_step
    smrd_step #(.WIDTH(WIDTH)) u_step (
      .clk        (clk),
      .rst        (rst),
      .in_valid   (stage_valid[k]),
      .in_ready   (stage_ready[k]),
      .in_flags   (stage_flags[k]),
      .in_acc     (stage_acc[k]),
      .in_low     (stage_low[k]),
      .in_divisor (stage_divisor[k]),
      .valid      (stage_valid[k+1]),
      .out_ready  (stage_ready[k+1]),
      .flags      (stage_flags[k+1]),
      .acc        (stage_acc[k+1]),
      .low        (stage_low[k+1]),
      .divisor    (stage_divisor[k+1])
    );
  end

  assign stage_ready[WIDTH] = fixup_ready;

  // Sign correction and output register.
  smrd_fixup #(.WIDTH(WIDTH)) u_fixup (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (stage_valid[WIDTH]),
    .in_ready       (fixup_ready),
    .in_flags       (stage_flags[WIDTH]),
    .in_acc         (stage_acc[WIDTH]),
    .in_low         (stage_low[WIDTH]),
    .valid          (result.valid),
    .out_ready      (result.ready),
    .quotient_bits  (result.quotient_bits),
    .remainder_bits (result.remainder_bits),
    .overflow       (result.overflow)
  );

  // The divisor is not needed after the last step.
  logic unused_divisor;
  assign unused_divisor = ^stage_divisor[WIDTH];

endmodule

// File: verif/sign_magnitude_restoring_divider_unit_tb.sv
// ----------------------------------------------------------------------------
// sign_magnitude_restoring_divider_unit_tb: self-checking bench for the divider
// Drives signed-magnitude operand pairs through the valid/ready operand channel
// and checks every result against an in-bench restoring-division predictor.
// Covers overflow bounds, sign handling, random traffic with gaps on both
// sides, back-to-back streaming, a long output stall and a drained pause.
// ----------------------------------------------------------------------------
module sign_magnitude_restoring_divider_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIDTH       = 16;
  localparam int LATENCY     = WIDTH + 2;
  localparam int MAX_GAP     = 12;
  localparam int HOLD_CYCLES = 200;
  localparam int CYCLE_LIMIT = 300000;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [WIDTH-1:0] quotient_bits;
    logic [WIDTH-1:0] remainder_bits;
    logic             overflow;
  } division_t;

  logic clk;
  logic rst;

  smrd_in_if  #(.WIDTH(WIDTH)) operand ();
  smrd_out_if #(.WIDTH(WIDTH)) result ();

  sign_magnitude_restoring_divider_unit #(.WIDTH(WIDTH)) uut (
    .clk     (clk),
    .rst     (rst),
    .operand (operand),
    .result  (result)
  );

  // Quotients and remainders still owed by the block, oldest first.
  division_t pending_divisions[$];
  int        mismatch_count;
  int        cycle_count;
  bit        source_gaps;
  bit        sink_gaps;
  int        hold_off_request;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Signed-magnitude restoring division, one shift-subtract step per bit.
  function automatic division_t divide_sign_magnitude(input logic dividend_neg,
                                                      input logic [2*WIDTH-1:0] dividend,
                                                      input logic divisor_neg,
                                                      input logic [WIDTH-1:0] divisor);
    logic [WIDTH:0]   partial;
    logic [WIDTH-1:0] low;
    division_t        quot;
    int               step;
    quot = '0;
    if (divisor == '0 || dividend[2*WIDTH-1:WIDTH] >= divisor) begin
      quot.overflow = 1'b1;
      return quot;
    end
    partial = {1'b0, dividend[2*WIDTH-1:WIDTH]};
    low     = dividend[WIDTH-1:0];
    for (step = 0; step < WIDTH; step++) begin
      partial = {partial[WIDTH-1:0], low[WIDTH-1]};
      low     = {low[WIDTH-2:0], 1'b0};
      if (partial >= {1'b0, divisor}) begin
        partial = partial - {1'b0, divisor};
        low[0]  = 1'b1;
      end
    end
    // Negating zero leaves zero, so no special handling is needed here.
    quot.quotient_bits  = (dividend_neg != divisor_neg) ? WIDTH'(0) - low : low;
    quot.remainder_bits = dividend_neg ? WIDTH'(0) - partial[WIDTH-1:0] : partial[WIDTH-1:0];
    return quot;
  endfunction

  // Offer one operand pair and hold it until the block takes the transaction.
  task automatic send_division(input logic dividend_neg, input logic [2*WIDTH-1:0] dividend,
                               input logic divisor_neg, input logic [WIDTH-1:0] divisor);
    int gap;
    gap = source_gaps ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      operand.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    operand.valid              <= 1'b1;
    operand.dividend_sign      <= dividend_neg;
    operand.dividend_magnitude <= dividend;
    operand.divisor_sign       <= divisor_neg;
    operand.divisor_magnitude  <= divisor;
    do @(posedge clk); while (!operand.ready);
    pending_divisions.push_back(divide_sign_magnitude(dividend_neg, dividend,
                                                      divisor_neg, divisor));
  endtask

  // Stop offering and wait until every owed result has come back.
  task automatic wait_for_results();
    operand.valid <= 1'b0;
    while (pending_divisions.size() != 0) @(posedge clk);
  endtask

  // Mostly well-formed divisions with random content, plus overflow and noise.
  task automatic send_random_division();
    logic [WIDTH-1:0]   divisor;
    logic [2*WIDTH-1:0] dividend;
    int                 pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      divisor  = ($urandom_range(0, 1) != 0) ? WIDTH'($urandom_range(1, 2**WIDTH - 1))
                                             : WIDTH'($urandom_range(1, 255));
      dividend = {WIDTH'($urandom_range(0, divisor - 1)), WIDTH'($urandom())};
    end else if (pick < 85) begin
      divisor  = WIDTH'($urandom());
      dividend = $urandom();
    end else if (pick < 92) begin
      divisor  = '0;
      dividend = $urandom();
    end else if (pick < 97) begin
      divisor  = WIDTH'($urandom_range(1, 2**WIDTH - 1));
      dividend = {divisor, WIDTH'($urandom())};
    end else begin
      divisor  = WIDTH'($urandom_range(1, 20));
      dividend = $urandom_range(0, 1000);
    end
    send_division(1'($urandom_range(0, 1)), dividend, 1'($urandom_range(0, 1)), divisor);
  endtask

  // Overflow boundary, zero divisor and full-scale operands.
  task automatic test_overflow_bounds();
    source_gaps = 1'b0;
    sink_gaps   = 1'b0;
    send_division(1'b0, 32'h0000_0000, 1'b0, 16'h0000);
    send_division(1'b1, 32'hFFFF_FFFF, 1'b1, 16'h0000);
    send_division(1'b0, 32'h0005_0000, 1'b0, 16'h0005);
    send_division(1'b0, 32'h0004_FFFF, 1'b0, 16'h0005);
    send_division(1'b1, 32'hFFFF_FFFF, 1'b0, 16'hFFFF);
    send_division(1'b0, 32'hFFFE_FFFF, 1'b0, 16'hFFFF);
    send_division(1'b1, 32'hFFFE_FFFF, 1'b1, 16'hFFFF);
    send_division(1'b0, 32'h0000_FFFF, 1'b0, 16'h0001);
    send_division(1'b0, 32'h0000_FFFF, 1'b1, 16'h0001);
    send_division(1'b0, 32'h0001_0000, 1'b0, 16'h0001);
    send_division(1'b1, 32'h8000_0000, 1'b0, 16'h8001);
    wait_for_results();
  endtask

  // Every sign combination, negative zero and exact division.
  task automatic test_sign_handling();
    send_division(1'b0, 32'd1000, 1'b0, 16'd7);
    send_division(1'b0, 32'd1000, 1'b1, 16'd7);
    send_division(1'b1, 32'd1000, 1'b0, 16'd7);
    send_division(1'b1, 32'd1000, 1'b1, 16'd7);
    send_division(1'b1, 32'd0, 1'b0, 16'd3);
    send_division(1'b0, 32'd0, 1'b1, 16'd3);
    send_division(1'b1, 32'd42, 1'b0, 16'd6);
    send_division(1'b1, 32'd5, 1'b1, 16'd7);
    send_division(1'b0, 32'd5, 1'b1, 16'd7);
    wait_for_results();
  endtask

  // Random traffic with gaps drawn on both channels.
  task automatic test_random_with_gaps(input int count);
    source_gaps = 1'b1;
    sink_gaps   = 1'b1;
    repeat (count) send_random_division();
  endtask

  // Random traffic at full rate on both channels.
  task automatic test_back_to_back(input int count);
    source_gaps = 1'b0;
    sink_gaps   = 1'b0;
    repeat (count) send_random_division();
  endtask

  // The receiver stalls for a long stretch while operands keep coming.
  task automatic test_result_stall(input int count);
    source_gaps      = 1'b0;
    sink_gaps        = 1'b0;
    hold_off_request = HOLD_CYCLES;
    repeat (count) send_random_division();
    wait_for_results();
  endtask

  // The sender pauses mid-stream until the pipeline has fully drained.
  task automatic test_drained_pause(input int count);
    source_gaps = 1'b1;
    sink_gaps   = 1'b1;
    repeat (count) send_random_division();
    wait_for_results();
    repeat (count) send_random_division();
    wait_for_results();
  endtask

  // Result side: draws a stall per transaction and honors long hold-off requests.
  initial begin : result_receiver
    int stall;
    int hold;
    result.ready <= 1'b0;
    @(negedge rst);
    forever begin
      if (hold_off_request != 0) begin
        hold             = hold_off_request;
        hold_off_request = 0;
        result.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      stall = sink_gaps ? $urandom_range(0, MAX_GAP) : 0;
      if (stall > 0) begin
        result.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result.ready <= 1'b1;
      do @(posedge clk); while (!result.valid);
    end
  end

  // Compare each accepted result with the oldest owed division.
  always @(posedge clk) begin : result_check
    division_t got;
    division_t want;
    if (!rst && result.valid && result.ready) begin
      got = '{result.quotient_bits, result.remainder_bits, result.overflow};
      if (pending_divisions.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result: quotient=%h remainder=%h overflow=%b",
                   got.quotient_bits, got.remainder_bits, got.overflow);
      end else begin
        want = pending_divisions.pop_front();
        if (got.quotient_bits !== want.quotient_bits ||
            got.remainder_bits !== want.remainder_bits ||
            got.overflow !== want.overflow) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("mismatch: expected q=%h r=%h ovf=%b, got q=%h r=%h ovf=%b",
                     want.quotient_bits, want.remainder_bits, want.overflow,
                     got.quotient_bits, got.remainder_bits, got.overflow);
        end
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[sign_magnitude_restoring_divider_unit] ERROR");
      $finish;
    end
  end

  // Test sequence.
  initial begin
    rst                        = 1'b1;
    operand.valid              = 1'b0;
    operand.dividend_sign      = 1'b0;
    operand.dividend_magnitude = '0;
    operand.divisor_sign       = 1'b0;
    operand.divisor_magnitude  = '0;
    mismatch_count             = 0;
    cycle_count                = 0;
    source_gaps                = 1'b0;
    sink_gaps                  = 1'b0;
    hold_off_request           = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_overflow_bounds();
    test_sign_handling();
    test_random_with_gaps(540);
    test_back_to_back(150);
    test_result_stall(60);
    test_drained_pause(40);

    wait_for_results();
    repeat (LATENCY + 4) @(posedge clk);
    if (mismatch_count == 0 && pending_divisions.size() == 0)
      $display("[sign_magnitude_restoring_divider_unit] OK");
    else
      $display("[sign_magnitude_restoring_divider_unit] ERROR");
    $finish;
  end

endmodule

// File: sign_magnitude_restoring_divider_unit.f
rtl/smrd_pkg.sv
rtl/smrd_ifs.sv
rtl/smrd_entry.sv
rtl/smrd_step.sv
rtl/smrd_fixup.sv
rtl/sign_magnitude_restoring_divider_unit.sv
verif/sign_magnitude_restoring_divider_unit_tb.sv
